FILE: rtl/core/heightmap_triangle_sampler_core_assert.svh
// assertion macros for the heightmap triangle sampler
// included by modules that carry concurrent checks, no other dependencies
`ifndef HEIGHTMAP_TRIANGLE_SAMPLER_CORE_ASSERT_SVH
`define HEIGHTMAP_TRIANGLE_SAMPLER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define HTS_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");
`define HTS_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("reset assertion failed");
`else
`define HTS_ASSERT(lbl, clk, rstn, prop)
`define HTS_ASSERT_RST(lbl, clk, prop)
`endif
`endif

FILE: rtl/core/hts_pkg.sv
// shared types and constants for the heightmap triangle sampler
// no dependencies
package hts_pkg;

    typedef enum logic [1:0] {
        CMD_QUERY  = 2'd0,
        CMD_CORNER = 2'd1,
        CMD_CENTER = 2'd2,
        CMD_HOLE   = 2'd3
    } t_command;

    typedef enum logic [1:0] {
        CFG_HAS_HEIGHTMAP = 2'd0,
        CFG_HAS_HOLES     = 2'd1,
        CFG_FLAT_HEIGHT   = 2'd2,
        CFG_SCALE         = 2'd3
    } t_cfg_index;

    localparam logic [23:0] SCALE_RESET = 24'd4026532;
    localparam int          DIV_SHIFT   = 24;

    // corner write position split from a row-major index
    typedef struct packed {
        logic [8:0] row;
        logic [8:0] col;
        logic       ok;
    } t_corner_pos;

endpackage

FILE: rtl/core/hts_in_if.sv
// input channel of the sampler: commands and query positions
// depends on nothing
interface hts_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [14:0]        write_index;
    logic signed [31:0] write_value;

    modport source (output valid, command, pos_x, pos_y, write_index, write_value,
                    input ready);
    modport sink (input valid, command, pos_x, pos_y, write_index, write_value,
                  output ready);
endinterface

FILE: rtl/core/hts_out_if.sv
// result channel of the sampler: height and hole flag
// depends on nothing
interface hts_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] height;
    logic               is_hole;

    modport source (output valid, height, is_hole, input ready);
    modport sink (input valid, height, is_hole, output ready);
endinterface

FILE: rtl/core/hts_corner_div.sv
// splits a row-major corner index into row and column (divide by grid_res + 1)
// depends on hts_pkg
module hts_corner_div #(
    parameter int GRID_RES = 128
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic [14:0]          i_index,
    output hts_pkg::t_corner_pos o_pos
);
    localparam int CDIM   = GRID_RES + 1;
    localparam int CCOUNT = CDIM * CDIM;
    localparam int RECIP  = (1 << hts_pkg::DIV_SHIFT) / CDIM;
    localparam int QW     = 9;

    logic [QW-1:0] r_q;
    logic [14:0]   r_w;
    logic [47:0]   n_prod;
    logic [17:0]   rem0;
    logic [17:0]   rem1;
    logic          fix;

    assign n_prod = 48'(i_index) * 48'(RECIP);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_q <= n_prod[hts_pkg::DIV_SHIFT +: QW];
            r_w <= i_index;
        end
    end

    always_comb begin
        rem0 = 18'(r_w) - 18'(r_q) * 18'(CDIM);
        fix  = rem0 >= 18'(CDIM);
        rem1 = fix ? rem0 - 18'(CDIM) : rem0;
        o_pos.row = fix ? r_q + QW'(1) : r_q;
        o_pos.col = rem1[QW-1:0];
        o_pos.ok  = 32'(r_w) < 32'(CCOUNT);
    end
endmodule

FILE: rtl/core/heightmap_triangle_sampler_core.sv
// heightmap triangle sampler, top level; depends on hts_pkg, hts_in_if, hts_out_if,
// hts_corner_div and the assertion header
// an accepted beat passes r1, r2, r3 and r4 on its way to the output register
// throughput: one beat per cycle; the whole pipeline holds while a result is not taken
// reset clears configuration and pipeline valids; height memories hold garbage until written
`include "heightmap_triangle_sampler_core_assert.svh"
module heightmap_triangle_sampler_core #(
    parameter int GRID_RES    = 128,
    parameter int HEIGHT_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata,
    hts_in_if.sink      i_query,
    hts_out_if.source   o_result
);
    localparam int HB     = HEIGHT_BITS;
    localparam int RB     = $clog2(GRID_RES);
    localparam int HOB    = RB - 3;
    localparam int BDEPTH = 1 << (2 * RB);
    localparam int CDEPTH = GRID_RES * GRID_RES;
    localparam int HDEPTH = 1 << (2 * HOB);
    localparam int GB     = 40 + RB;
    localparam int AW     = HB + 3;
    localparam int PW     = AW + 17;
    localparam int SW     = AW + 18;
    localparam int SHW    = SW - 16;
    localparam longint HMAXL = (64'sd1 <<< (HB - 1)) - 64'sd1;
    localparam longint HMINL = -HMAXL - 64'sd1;

    // configuration
    logic               r_has_hm;
    logic               r_has_holes;
    logic signed [31:0] r_flat;
    logic [23:0]        r_scale;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_has_hm    <= 1'b0;
            r_has_holes <= 1'b0;
            r_flat      <= '0;
            r_scale     <= hts_pkg::SCALE_RESET;
        end else if (i_cfg_we) begin
            case (hts_pkg::t_cfg_index'(i_cfg_index))
                hts_pkg::CFG_HAS_HEIGHTMAP: r_has_hm    <= i_cfg_wdata[0];
                hts_pkg::CFG_HAS_HOLES:     r_has_holes <= i_cfg_wdata[0];
                hts_pkg::CFG_FLAT_HEIGHT:   r_flat      <= i_cfg_wdata;
                hts_pkg::CFG_SCALE:         r_scale     <= i_cfg_wdata[23:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic r_out_vld;
    logic r_out_hole;
    logic signed [31:0] r_out_height;

    assign en            = !(r_out_vld && !o_result.ready);
    assign i_query.ready = en;

    // stage 1: position scaling
    logic                     r1_vld;
    hts_pkg::t_command        r1_cmd;
    logic signed [56:0]       r1_px;
    logic signed [56:0]       r1_py;
    logic signed [HB-1:0]     r1_wval;
    logic [14:0]              r1_widx;
    logic signed [56:0]       n_px;
    logic signed [56:0]       n_py;

    assign n_px = 57'(i_query.pos_x) * $signed({33'd0, r_scale});
    assign n_py = 57'(i_query.pos_y) * $signed({33'd0, r_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (en) begin
            r1_vld <= i_query.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_cmd  <= hts_pkg::t_command'(i_query.command);
            r1_px   <= n_px;
            r1_py   <= n_py;
            r1_wval <= i_query.write_value[HB-1:0];
            r1_widx <= i_query.write_index;
        end
    end

    hts_pkg::t_corner_pos cpos;

    hts_corner_div #(.GRID_RES(GRID_RES)) u_div (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_index (i_query.write_index),
        .o_pos   (cpos)
    );

    // grid position; the tile base is a multiple of the wrap period
    logic [GB-1:0] gx;
    logic [GB-1:0] gy;
    logic [RB-1:0] row;
    logic [RB-1:0] col;

    assign gx  = '0 - r1_px[GB-1:0];
    assign gy  = '0 - r1_py[GB-1:0];
    assign row = gx[GB-1:40];
    assign col = gy[GB-1:40];

    logic wr_corner;
    logic wr_center;
    logic wr_hole;
    logic [1:0]      wbank;
    logic [2*RB-1:0] waddr_c;

    assign wr_corner = en && r1_vld && r1_cmd == hts_pkg::CMD_CORNER && cpos.ok;
    assign wr_center = en && r1_vld && r1_cmd == hts_pkg::CMD_CENTER
                       && 32'(r1_widx) < 32'(CDEPTH);
    assign wr_hole   = en && r1_vld && r1_cmd == hts_pkg::CMD_HOLE
                       && 32'(r1_widx) < 32'(HDEPTH);
    assign wbank     = {cpos.row[0], cpos.col[0]};
    assign waddr_c   = {cpos.row[RB:1], cpos.col[RB:1]};

    // corner banks by row and column parity
    logic signed [HB-1:0] mem_c [4][BDEPTH];
    logic signed [HB-1:0] r2_c [4];

    for (genvar b = 0; b < 4; b++) begin : g_bank
        logic [RB:0]     rrow;
        logic [RB:0]     rcol;
        logic [2*RB-1:0] raddr;

        assign rrow  = (row[0] == 1'(b >> 1)) ? {1'b0, row} : {1'b0, row} + (RB+1)'(1);
        assign rcol  = (col[0] == 1'(b)) ? {1'b0, col} : {1'b0, col} + (RB+1)'(1);
        assign raddr = {rrow[RB:1], rcol[RB:1]};

        always_ff @(posedge i_clk) begin
            if (en) begin
                if (wr_corner && wbank == 2'(b)) begin
                    mem_c[b][waddr_c] <= r1_wval;
                end
                r2_c[b] <= mem_c[b][raddr];
            end
        end
    end

    logic signed [HB-1:0] mem_ctr [CDEPTH];
    logic [15:0]          mem_hole [HDEPTH];
    logic signed [HB-1:0] r2_ctr;
    logic [15:0]          r2_mask;

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (wr_center) begin
                mem_ctr[r1_widx[2*RB-1:0]] <= r1_wval;
            end
            r2_ctr <= mem_ctr[{row, col}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (wr_hole) begin
                mem_hole[r1_widx[2*HOB-1:0]] <= r1_wval[15:0];
            end
            r2_mask <= mem_hole[{row[RB-1:3], col[RB-1:3]}];
        end
    end

    // stage 2: triangle setup
    logic        r2_vld;
    logic        r2_r0;
    logic        r2_c0;
    logic [15:0] r2_fx;
    logic [15:0] r2_fy;
    logic [3:0]  r2_hbit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (en) begin
            r2_vld <= r1_vld && r1_cmd == hts_pkg::CMD_QUERY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r2_r0   <= row[0];
            r2_c0   <= col[0];
            r2_fx   <= gx[39:24];
            r2_fy   <= gy[39:24];
            r2_hbit <= {row[2:1], col[2:1]};
        end
    end

    logic signed [AW-1:0] h1, h2, h3, h4, h5;
    logic signed [AW-1:0] n_a, n_b, n_c;
    logic [16:0]          fsum;
    logic                 n_hole;

    always_comb begin
        h1     = AW'(r2_c[{r2_r0, r2_c0}]);
        h2     = AW'(r2_c[{~r2_r0, r2_c0}]);
        h3     = AW'(r2_c[{r2_r0, ~r2_c0}]);
        h4     = AW'(r2_c[{~r2_r0, ~r2_c0}]);
        h5     = AW'(r2_ctr) <<< 1;
        fsum   = {1'b0, r2_fx} + {1'b0, r2_fy};
        n_hole = r_has_holes && r2_mask[r2_hbit];
        if (!fsum[16]) begin
            if (r2_fx > r2_fy) begin
                n_a = h2 - h1;      n_b = h5 - h1 - h2; n_c = h1;
            end else begin
                n_a = h5 - h1 - h3; n_b = h3 - h1;      n_c = h1;
            end
        end else begin
            if (r2_fx > r2_fy) begin
                n_a = h2 + h4 - h5; n_b = h4 - h2;      n_c = h5 - h4;
            end else begin
                n_a = h4 - h3;      n_b = h3 + h4 - h5; n_c = h5 - h4;
            end
        end
    end

    // stage 3: products
    logic                 r3_vld;
    logic                 r3_hole;
    logic signed [AW-1:0] r3_a, r3_b, r3_c;
    logic [15:0]          r3_fx, r3_fy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_hole <= n_hole;
            r3_a    <= n_a;
            r3_b    <= n_b;
            r3_c    <= n_c;
            r3_fx   <= r2_fx;
            r3_fy   <= r2_fy;
        end
    end

    logic                 r4_vld;
    logic                 r4_hole;
    logic signed [PW-1:0] r4_pa, r4_pb;
    logic signed [AW-1:0] r4_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r4_hole <= r3_hole;
            r4_pa   <= PW'(r3_a) * PW'($signed({1'b0, r3_fx}));
            r4_pb   <= PW'(r3_b) * PW'($signed({1'b0, r3_fy}));
            r4_c    <= r3_c;
        end
    end

    // stage 4: sum, round, saturate
    logic signed [SW-1:0]  sum;
    logic signed [SHW-1:0] shr;
    logic signed [HB-1:0]  hsat;
    logic signed [HB-1:0]  fsat;
    logic signed [31:0]    n_height;

    always_comb begin
        sum = SW'(r4_pa) + SW'(r4_pb) + (SW'(r4_c) <<< 16) + SW'(32768);
        shr = SHW'(sum >>> 16);
        if (shr > SHW'(HMAXL)) begin
            hsat = HB'(HMAXL);
        end else if (shr < SHW'(HMINL)) begin
            hsat = HB'(HMINL);
        end else begin
            hsat = shr[HB-1:0];
        end
        if (33'(r_flat) > 33'(HMAXL)) begin
            fsat = HB'(HMAXL);
        end else if (33'(r_flat) < 33'(HMINL)) begin
            fsat = HB'(HMINL);
        end else begin
            fsat = r_flat[HB-1:0];
        end
        if (!r_has_hm) begin
            n_height = 32'(fsat);
        end else if (r4_hole) begin
            n_height = '0;
        end else begin
            n_height = 32'(hsat);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r4_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_height <= n_height;
            r_out_hole   <= r_has_hm && r4_hole;
        end
    end

    assign o_result.valid   = r_out_vld;
    assign o_result.height  = r_out_height;
    assign o_result.is_hole = r_out_hole;

    `HTS_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !r_out_vld && !r1_vld)
    `HTS_ASSERT(a_stall_freeze, i_clk, i_rst_n, !en |=> $stable({r1_vld, r2_vld, r3_vld, r4_vld}))
    `HTS_ASSERT(a_hole_zero, i_clk, i_rst_n, (r_out_vld && r_out_hole) |-> r_out_height == 32'sd0)
    `HTS_ASSERT(a_query_enters, i_clk, i_rst_n, (i_query.valid && en) |=> r1_vld)
endmodule
